@@ rtl/blake2s_hash_engine_core_defines.svh @@
// assertion macros for the blake2s hash engine checker
`ifndef BLAKE2S_HASH_ENGINE_CORE_DEFINES_SVH
`define BLAKE2S_HASH_ENGINE_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define B2S_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("b2s check failed");

// antecedent implies consequent in the next cycle
`define B2S_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("b2s check failed");

`endif

@@ rtl/b2s_pkg.sv @@
// types, constants and tables for the blake2s hash engine
package b2s_pkg;

  typedef struct packed {
    logic        action;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
  } b2s_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_bytes;
    logic        last;
  } b2s_out_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } b2s_quad_t;

  localparam logic       ACT_ABSORB   = 1'b0;
  localparam logic       ACT_FINALIZE = 1'b1;
  localparam logic [31:0] PARAM_CONST = 32'h0101_0000;
  localparam logic [5:0] DS_MAX       = 6'd32;
  localparam logic [3:0] LAST_ROUND   = 4'd9;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [3:0] SIGMA [10][16] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
      4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
    '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
      4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
    '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
      4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
    '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
      4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
    '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
      4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
    '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
      4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
    '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
      4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
    '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
      4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
    '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
      4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
  };

  // working vector positions a, b, c, d for each of the eight mixes
  localparam logic [3:0] MIX_IDX [8][4] = '{
    '{4'd0, 4'd4, 4'd8, 4'd12}, '{4'd1, 4'd5, 4'd9, 4'd13},
    '{4'd2, 4'd6, 4'd10, 4'd14}, '{4'd3, 4'd7, 4'd11, 4'd15},
    '{4'd0, 4'd5, 4'd10, 4'd15}, '{4'd1, 4'd6, 4'd11, 4'd12},
    '{4'd2, 4'd7, 4'd8, 4'd13}, '{4'd3, 4'd4, 4'd9, 4'd14}
  };

endpackage

@@ rtl/blake2s_hash_engine_core.sv @@
// blake2s hash engine top level
// Unkeyed BLAKE2s. Input channel in_valid/in_ready carries in_item:
// absorb (0 to 4 bytes, packed low) or finalize. Output channel
// out_valid/out_ready gives one digest word per transaction, a quarter
// of the digest length rounded up in all, the last one flagged.
// cfg_valid/cfg_ready writes the digest length and restarts the hash;
// it is taken only while the engine is idle.
// The message block sits in a 16-word buffer memory with registered
// reads; each mixing step takes one message word from it.
// An absorb transaction writes its bytes into the buffer one by one
// before the input is ready again; when a full block has to be
// compressed first, that comes before the next byte (one half mix per
// cycle, 160 steps, plus the start, load and fold). A finalize
// transaction pads one byte per cycle up to the block end, compresses,
// then shows one digest word per cycle as the receiver takes them.
// A stalled receiver holds the current word; no input is accepted
// until the last word is taken. Reset restores a digest length of 32 and
// the initial chaining value; the buffer needs no clearing.
module blake2s_hash_engine_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  b2s_pkg::b2s_in_t   in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output b2s_pkg::b2s_out_t  out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [5:0]         cfg_data
);

  typedef enum logic [6:0] {
    IDLE   = 7'b0000001,
    ABSORB = 7'b0000010,
    PAD    = 7'b0000100,
    INIT   = 7'b0001000,
    ROUND  = 7'b0010000,
    FOLD   = 7'b0100000,
    EMIT   = 7'b1000000
  } state_t;

  state_t      state;
  logic [6:0]  pos;
  logic [63:0] counter;
  logic [63:0] tcount;
  logic        fin;
  logic        ret_emit;
  logic [31:0] data;
  logic [2:0]  cnt;
  logic [2:0]  idx;
  logic [3:0]  rnd;
  logic [3:0]  step;
  logic [2:0]  k;
  logic [5:0]  ds;
  logic [31:0] h [8];
  logic [31:0] v [16];

  logic [7:0]  buf_mem [16][4];
  logic        we;
  logic [7:0]  wbyte;
  logic [3:0]  raddr;
  logic [31:0] rdata;

  logic [5:0]  ds_clamped;
  logic [3:0]  rnd_next, step_next;
  logic [2:0]  g;
  b2s_pkg::b2s_quad_t q_in, q_out;
  logic [5:0]  rem;
  logic [31:0] wsel;

  assign in_ready  = (state == IDLE) && !cfg_valid;
  assign cfg_ready = (state == IDLE);
  assign out_valid = (state == EMIT);

  always_comb begin
    if (cfg_data == 6'd0) begin
      ds_clamped = 6'd1;
    end else if (cfg_data > b2s_pkg::DS_MAX) begin
      ds_clamped = b2s_pkg::DS_MAX;
    end else begin
      ds_clamped = cfg_data;
    end
  end

  // next mixing step, so the registered read has its word ready when that step begins
  always_comb begin
    if (step == 4'd15) begin
      step_next = 4'd0;
      rnd_next  = (rnd == b2s_pkg::LAST_ROUND) ? 4'd0 : rnd + 4'd1;
    end else begin
      step_next = step + 4'd1;
      rnd_next  = rnd;
    end
    raddr = (state == INIT) ? b2s_pkg::SIGMA[0][0] : b2s_pkg::SIGMA[rnd_next][step_next];
  end

  assign we    = (state == ABSORB && idx != cnt && !pos[6]) || (state == PAD && !pos[6]);
  assign wbyte = (state == ABSORB) ? data[7:0] : 8'd0;

  always_ff @(posedge clk) begin
    if (we) begin
      buf_mem[pos[5:2]][pos[1:0]] <= wbyte;
    end
    rdata <= {buf_mem[raddr][3], buf_mem[raddr][2], buf_mem[raddr][1], buf_mem[raddr][0]};
  end

  assign g = step[3:1];
  always_comb begin
    q_in.a = v[b2s_pkg::MIX_IDX[g][0]];
    q_in.b = v[b2s_pkg::MIX_IDX[g][1]];
    q_in.c = v[b2s_pkg::MIX_IDX[g][2]];
    q_in.d = v[b2s_pkg::MIX_IDX[g][3]];
  end

  b2s_mix u_mix (
    .q_in  (q_in),
    .x     (rdata),
    .half  (step[0]),
    .q_out (q_out)
  );

  // digest word selection and byte masking
  always_comb begin
    rem  = ds - {1'b0, k, 2'b00};
    wsel = h[k];
    out_item.last = (rem <= 6'd4);
    if (rem >= 6'd4) begin
      out_item.word_bytes  = 3'd4;
      out_item.digest_word = wsel;
    end else begin
      out_item.word_bytes = rem[2:0];
      case (rem[1:0])
        2'd1:    out_item.digest_word = {24'd0, wsel[7:0]};
        2'd2:    out_item.digest_word = {16'd0, wsel[15:0]};
        2'd3:    out_item.digest_word = {8'd0, wsel[23:0]};
        default: out_item.digest_word = wsel;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      pos     <= 7'd0;
      counter <= 64'd0;
      ds      <= b2s_pkg::DS_MAX;
      idx     <= 3'd0;
      k       <= 3'd0;
      for (int i = 1; i < 8; i++) begin
        h[i] <= b2s_pkg::IV[i];
      end
      h[0] <= b2s_pkg::IV[0] ^ b2s_pkg::PARAM_CONST ^ {26'd0, b2s_pkg::DS_MAX};
    end else begin
      case (state)
        IDLE: begin
          if (cfg_valid) begin
            ds      <= ds_clamped;
            pos     <= 7'd0;
            counter <= 64'd0;
            for (int i = 1; i < 8; i++) begin
              h[i] <= b2s_pkg::IV[i];
            end
            h[0] <= b2s_pkg::IV[0] ^ b2s_pkg::PARAM_CONST ^ {26'd0, ds_clamped};
          end else if (in_valid) begin
            if (in_item.action == b2s_pkg::ACT_FINALIZE) begin
              tcount   <= counter + {57'd0, pos};
              fin      <= 1'b1;
              ret_emit <= 1'b1;
              state    <= PAD;
            end else begin
              data  <= in_item.data_word;
              cnt   <= (in_item.byte_count > 3'd4) ? 3'd4 : in_item.byte_count;
              idx   <= 3'd0;
              state <= ABSORB;
            end
          end
        end
        ABSORB: begin
          if (idx == cnt) begin
            state <= IDLE;
          end else if (pos[6]) begin
            // full block waits for a further byte before compression
            counter  <= counter + 64'd64;
            tcount   <= counter + 64'd64;
            fin      <= 1'b0;
            ret_emit <= 1'b0;
            pos      <= 7'd0;
            state    <= INIT;
          end else begin
            data <= {8'd0, data[31:8]};
            pos  <= pos + 7'd1;
            idx  <= idx + 3'd1;
          end
        end
        PAD: begin
          if (pos[6]) begin
            state <= INIT;
          end else begin
            pos <= pos + 7'd1;
          end
        end
        INIT: begin
          for (int i = 0; i < 8; i++) begin
            v[i] <= h[i];
          end
          for (int i = 0; i < 4; i++) begin
            v[i + 8] <= b2s_pkg::IV[i];
          end
          v[12] <= b2s_pkg::IV[4] ^ tcount[31:0];
          v[13] <= b2s_pkg::IV[5] ^ tcount[63:32];
          v[14] <= b2s_pkg::IV[6] ^ {32{fin}};
          v[15] <= b2s_pkg::IV[7];
          rnd   <= 4'd0;
          step  <= 4'd0;
          state <= ROUND;
        end
        ROUND: begin
          v[b2s_pkg::MIX_IDX[g][0]] <= q_out.a;
          v[b2s_pkg::MIX_IDX[g][1]] <= q_out.b;
          v[b2s_pkg::MIX_IDX[g][2]] <= q_out.c;
          v[b2s_pkg::MIX_IDX[g][3]] <= q_out.d;
          if (rnd == b2s_pkg::LAST_ROUND && step == 4'd15) begin
            state <= FOLD;
          end
          rnd  <= rnd_next;
          step <= step_next;
        end
        FOLD: begin
          for (int i = 0; i < 8; i++) begin
            h[i] <= h[i] ^ v[i] ^ v[i + 8];
          end
          k     <= 3'd0;
          state <= ret_emit ? EMIT : ABSORB;
        end
        EMIT: begin
          if (out_ready) begin
            if (out_item.last) begin
              pos     <= 7'd0;
              counter <= 64'd0;
              for (int i = 1; i < 8; i++) begin
                h[i] <= b2s_pkg::IV[i];
              end
              h[0]  <= b2s_pkg::IV[0] ^ b2s_pkg::PARAM_CONST ^ {26'd0, ds};
              state <= IDLE;
            end else begin
              k <= k + 3'd1;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

@@ rtl/b2s_mix.sv @@
// one half of the blake2s mixing function
module b2s_mix (
  input  b2s_pkg::b2s_quad_t q_in,
  input  logic [31:0]        x,
  input  logic               half,
  output b2s_pkg::b2s_quad_t q_out
);

  logic [31:0] a1, d0, d1, c1, b0, b1;

  always_comb begin
    a1 = q_in.a + q_in.b + x;
    d0 = q_in.d ^ a1;
    // first half rotates by 16 and 12, second half by 8 and 7
    d1 = half ? {d0[7:0], d0[31:8]} : {d0[15:0], d0[31:16]};
    c1 = q_in.c + d1;
    b0 = q_in.b ^ c1;
    b1 = half ? {b0[6:0], b0[31:7]} : {b0[11:0], b0[31:12]};
    q_out.a = a1;
    q_out.b = b1;
    q_out.c = c1;
    q_out.d = d1;
  end

endmodule

@@ rtl/b2s_checker.sv @@
// port-level checks for the blake2s hash engine, bound to the top level
`include "blake2s_hash_engine_core_defines.svh"

module b2s_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input b2s_pkg::b2s_out_t out_item,
  input logic              cfg_ready
);

  // a stalled digest word stays offered
  `B2S_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // no new transaction taken while a digest is being delivered
  `B2S_ASSERT_SAME(a_no_in_during_out, out_valid, !in_ready && !cfg_ready)
  // word_bytes stays within one to four
  `B2S_ASSERT_SAME(a_word_bytes, out_valid,
                   out_item.word_bytes != 3'd0 && out_item.word_bytes <= 3'd4)
  // after a non-final word is taken the next one follows at once
  `B2S_ASSERT_NEXT(a_next_word, out_valid && out_ready && !out_item.last, out_valid)

endmodule

bind blake2s_hash_engine_core b2s_checker u_b2s_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item),
  .cfg_ready (cfg_ready)
);
